### rtl/linked_list_deque_with_key_removal_core_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the linked list deque core.
// Every macro expects clk_i and rst_ni to be in scope.
// ---------------------------------------------------------------------------
`ifndef LINKED_LIST_DEQUE_WITH_KEY_REMOVAL_CORE_ASSERT_SVH
`define LINKED_LIST_DEQUE_WITH_KEY_REMOVAL_CORE_ASSERT_SVH

// Same-cycle implication
`define LLDQ_ASSERT(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("lldq: same-cycle check failed");

// Next-cycle implication
`define LLDQ_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("lldq: next-cycle check failed");

`endif

### rtl/lldq_pkg.sv
// ---------------------------------------------------------------------------
// lldq_pkg
// Sizes, codes and shared types of the linked list deque core.
// ---------------------------------------------------------------------------
package lldq_pkg;

  // Pool size and derived widths
  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int SLOT_W   = $clog2(CAPACITY + 1);
  localparam int CNT_W    = SLOT_W;

  // Field widths of the channels
  localparam int KIND_W   = 3;
  localparam int HANDLE_W = 16;
  localparam int KEY_W    = 64;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;
  localparam int ENTRY_W  = HANDLE_W + KEY_W;

  // Null link, and the last walk step allowed
  localparam logic [SLOT_W-1:0] NIL_SLOT  = SLOT_W'(CAPACITY);
  localparam logic [SLOT_W-1:0] LAST_STEP = SLOT_W'(CAPACITY - 1);

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_TAIL  = 3'd0,
    KIND_PUSH_HEAD  = 3'd1,
    KIND_REMOVE_KEY = 3'd2,
    KIND_POP_HEAD   = 3'd3,
    KIND_POP_TAIL   = 3'd4
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  // Link memory port request
  typedef struct packed {
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [SLOT_W-1:0] wr_data;
  } link_req_t;

  // Entry memory port request (handle above key)
  typedef struct packed {
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [ENTRY_W-1:0] wr_data;
  } ent_req_t;

  // Finished result handed to the output register
  typedef struct packed {
    status_e             status;
    logic [HANDLE_W-1:0] handle;
    logic [KEY_W-1:0]    key;
    logic [CNT_W-1:0]    count;
  } result_t;

  function automatic logic is_slot(logic [SLOT_W-1:0] s);
    return s < NIL_SLOT;
  endfunction

  function automatic logic [IDX_W-1:0] slot_idx(logic [SLOT_W-1:0] s);
    return s[IDX_W-1:0];
  endfunction

endpackage

### rtl/lldq_if.sv
// ---------------------------------------------------------------------------
// lldq request and response channels
// Valid/ready channels carrying one request or one result per transaction.
// ---------------------------------------------------------------------------
interface lldq_req_if;
  import lldq_pkg::*;

  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [HANDLE_W-1:0] item_handle;
  logic [KEY_W-1:0]    item_key;

  modport source (output valid, kind, item_handle, item_key, input ready);
  modport sink   (input valid, kind, item_handle, item_key, output ready);
endinterface

interface lldq_rsp_if;
  import lldq_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [HANDLE_W-1:0] out_handle;
  logic [KEY_W-1:0]    out_key;
  logic [COUNT_W-1:0]  entry_count;

  modport source (output valid, status, out_handle, out_key, entry_count, input ready);
  modport sink   (input valid, status, out_handle, out_key, entry_count, output ready);
endinterface

### rtl/lldq_ram.sv
// ---------------------------------------------------------------------------
// lldq_ram
// Simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module lldq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port, data held while not enabled
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

### rtl/lldq_ctrl.sv
// ---------------------------------------------------------------------------
// lldq_ctrl
// Sequencer of the list: list pointers, free list and the link walks.
// ---------------------------------------------------------------------------
module lldq_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           req_valid_i,
  output logic                           req_ready_o,
  input  logic [lldq_pkg::KIND_W-1:0]    kind_i,
  input  logic [lldq_pkg::HANDLE_W-1:0]  handle_i,
  input  logic [lldq_pkg::KEY_W-1:0]     key_i,
  output lldq_pkg::link_req_t            link_req_o,
  input  logic [lldq_pkg::SLOT_W-1:0]    link_rdata_i,
  output lldq_pkg::ent_req_t             ent_req_o,
  input  logic [lldq_pkg::ENTRY_W-1:0]   ent_rdata_i,
  output logic                           res_valid_o,
  output lldq_pkg::result_t              res_o,
  input  logic                           res_free_i
);
  import lldq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PUSH,
    S_PUSH_LINK,
    S_POP_HEAD,
    S_RM_WALK,
    S_RM_LINK,
    S_PT_WALK,
    S_PT_ONE,
    S_PT_CUT,
    S_RELEASE,
    S_DONE
  } state_e;

  state_e              state_q, state_d;
  logic [SLOT_W-1:0]   head_q, head_d;
  logic [SLOT_W-1:0]   tail_q, tail_d;
  logic [SLOT_W-1:0]   free_q, free_d;
  logic [SLOT_W-1:0]   fresh_q, fresh_d;   // slots at or above were never used
  logic [CNT_W-1:0]    count_q, count_d;
  status_e             status_q, status_d;
  logic [HANDLE_W-1:0] res_handle_q, res_handle_d;
  logic [KEY_W-1:0]    res_key_q, res_key_d;

  kind_e               kind_q, kind_d;
  logic [HANDLE_W-1:0] handle_q, handle_d;
  logic [KEY_W-1:0]    key_q, key_d;
  logic [SLOT_W-1:0]   slot_q, slot_d;     // push slot, popped slot or walk cursor
  logic [SLOT_W-1:0]   prev_q, prev_d;
  logic [SLOT_W-1:0]   link_q, link_d;
  logic [SLOT_W-1:0]   steps_q, steps_d;

  logic                accept;
  logic [HANDLE_W-1:0] rd_handle;
  logic [KEY_W-1:0]    rd_key;
  logic [CNT_W-1:0]    count_dec;

  assign req_ready_o = (state_q == S_IDLE);
  assign accept      = req_valid_i && req_ready_o;
  assign rd_handle   = ent_rdata_i[ENTRY_W-1:KEY_W];
  assign rd_key      = ent_rdata_i[KEY_W-1:0];
  assign count_dec   = (count_q != '0) ? count_q - CNT_W'(1) : count_q;

  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = '{status: status_q, handle: res_handle_q, key: res_key_q,
                         count: count_q};

  // Next state, pointer updates and memory requests
  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    tail_d       = tail_q;
    free_d       = free_q;
    fresh_d      = fresh_q;
    count_d      = count_q;
    status_d     = status_q;
    res_handle_d = res_handle_q;
    res_key_d    = res_key_q;
    kind_d       = kind_q;
    handle_d     = handle_q;
    key_d        = key_q;
    slot_d       = slot_q;
    prev_d       = prev_q;
    link_d       = link_q;
    steps_d      = steps_q;
    link_req_o   = '0;
    ent_req_o    = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          kind_d       = kind_e'(kind_i);
          handle_d     = handle_i;
          key_d        = key_i;
          status_d     = ST_MISS;
          res_handle_d = '0;
          res_key_d    = '0;
          state_d      = S_DONE;
          unique case (kind_e'(kind_i))
            KIND_PUSH_TAIL, KIND_PUSH_HEAD: begin
              if (!is_slot(free_q)) begin
                status_d = ST_FULL;
              end else begin
                slot_d             = free_q;
                link_req_o.rd_en   = 1'b1;
                link_req_o.rd_addr = slot_idx(free_q);
                state_d            = S_PUSH;
              end
            end
            KIND_REMOVE_KEY: begin
              if (is_slot(head_q)) begin
                link_req_o.rd_en   = 1'b1;
                link_req_o.rd_addr = slot_idx(head_q);
                ent_req_o.rd_en    = 1'b1;
                ent_req_o.rd_addr  = slot_idx(head_q);
                slot_d             = head_q;
                prev_d             = NIL_SLOT;
                steps_d            = '0;
                state_d            = S_RM_WALK;
              end
            end
            KIND_POP_HEAD: begin
              if (is_slot(head_q)) begin
                link_req_o.rd_en   = 1'b1;
                link_req_o.rd_addr = slot_idx(head_q);
                ent_req_o.rd_en    = 1'b1;
                ent_req_o.rd_addr  = slot_idx(head_q);
                slot_d             = head_q;
                state_d            = S_POP_HEAD;
              end
            end
            KIND_POP_TAIL: begin
              if (is_slot(tail_q)) begin
                ent_req_o.rd_en   = 1'b1;
                ent_req_o.rd_addr = slot_idx(tail_q);
                slot_d            = tail_q;
                if (head_q == tail_q) begin
                  state_d = S_PT_ONE;
                end else begin
                  link_req_o.rd_en   = 1'b1;
                  link_req_o.rd_addr = slot_idx(head_q);
                  prev_d             = head_q;
                  steps_d            = '0;
                  state_d            = S_PT_WALK;
                end
              end
            end
            default: ;  // unused codes: miss with count unchanged
          endcase
        end
      end

      // Store entry, take the slot off the free list
      S_PUSH: begin
        ent_req_o.wr_en   = 1'b1;
        ent_req_o.wr_addr = slot_idx(slot_q);
        ent_req_o.wr_data = {handle_q, key_q};
        if (slot_q >= fresh_q) begin
          free_d  = slot_q + SLOT_W'(1);
          fresh_d = slot_q + SLOT_W'(1);
        end else begin
          free_d = link_rdata_i;
        end
        count_d            = count_q + CNT_W'(1);
        status_d           = ST_DONE;
        link_req_o.wr_en   = 1'b1;
        link_req_o.wr_addr = slot_idx(slot_q);
        state_d            = S_DONE;
        if (kind_q == KIND_PUSH_TAIL) begin
          link_req_o.wr_data = NIL_SLOT;
          if (!is_slot(head_q)) begin
            head_d = slot_q;
          end
          if (is_slot(tail_q)) begin
            state_d = S_PUSH_LINK;
          end else begin
            tail_d = slot_q;
          end
        end else begin
          link_req_o.wr_data = head_q;
          head_d             = slot_q;
          if (!is_slot(tail_q)) begin
            tail_d = slot_q;
          end
        end
      end

      // Hook the new slot behind the old tail
      S_PUSH_LINK: begin
        link_req_o.wr_en   = 1'b1;
        link_req_o.wr_addr = slot_idx(tail_q);
        link_req_o.wr_data = slot_q;
        tail_d             = slot_q;
        state_d            = S_DONE;
      end

      S_POP_HEAD: begin
        status_d     = ST_DONE;
        res_handle_d = rd_handle;
        res_key_d    = rd_key;
        if (slot_q == tail_q) begin
          tail_d = NIL_SLOT;
        end
        head_d             = link_rdata_i;
        count_d            = count_dec;
        link_req_o.wr_en   = 1'b1;
        link_req_o.wr_addr = slot_idx(slot_q);
        link_req_o.wr_data = free_q;
        free_d             = slot_q;
        state_d            = S_DONE;
      end

      // One linked slot checked per cycle
      S_RM_WALK: begin
        if (rd_key == key_q) begin
          status_d           = ST_DONE;
          res_handle_d       = rd_handle;
          res_key_d          = rd_key;
          count_d            = count_dec;
          link_req_o.wr_en   = 1'b1;
          link_req_o.wr_addr = slot_idx(slot_q);
          link_req_o.wr_data = free_q;
          free_d             = slot_q;
          if (!is_slot(link_rdata_i)) begin
            tail_d = prev_q;
          end
          if (is_slot(prev_q)) begin
            link_d  = link_rdata_i;
            state_d = S_RM_LINK;
          end else begin
            head_d  = link_rdata_i;
            state_d = S_DONE;
          end
        end else if (steps_q >= LAST_STEP || !is_slot(link_rdata_i)) begin
          state_d = S_DONE;
        end else begin
          link_req_o.rd_en   = 1'b1;
          link_req_o.rd_addr = slot_idx(link_rdata_i);
          ent_req_o.rd_en    = 1'b1;
          ent_req_o.rd_addr  = slot_idx(link_rdata_i);
          prev_d             = slot_q;
          slot_d             = link_rdata_i;
          steps_d            = steps_q + SLOT_W'(1);
        end
      end

      // Unlink the removed slot from its predecessor
      S_RM_LINK: begin
        link_req_o.wr_en   = 1'b1;
        link_req_o.wr_addr = slot_idx(prev_q);
        link_req_o.wr_data = link_q;
        state_d            = S_DONE;
      end

      // Find the slot whose link points at the tail
      S_PT_WALK: begin
        if (link_rdata_i == slot_q) begin
          state_d = S_PT_CUT;
        end else begin
          prev_d = link_rdata_i;
          if (!is_slot(link_rdata_i)) begin
            state_d = S_DONE;
          end else if (steps_q >= LAST_STEP) begin
            state_d = S_PT_CUT;
          end else begin
            link_req_o.rd_en   = 1'b1;
            link_req_o.rd_addr = slot_idx(link_rdata_i);
            steps_d            = steps_q + SLOT_W'(1);
          end
        end
      end

      S_PT_ONE: begin
        status_d     = ST_DONE;
        res_handle_d = rd_handle;
        res_key_d    = rd_key;
        head_d       = NIL_SLOT;
        tail_d       = NIL_SLOT;
        count_d      = '0;
        state_d      = S_RELEASE;
      end

      S_PT_CUT: begin
        status_d           = ST_DONE;
        res_handle_d       = rd_handle;
        res_key_d          = rd_key;
        link_req_o.wr_en   = 1'b1;
        link_req_o.wr_addr = slot_idx(prev_q);
        link_req_o.wr_data = NIL_SLOT;
        tail_d             = prev_q;
        count_d            = count_dec;
        state_d            = S_RELEASE;
      end

      // Freed slot goes to the front of the free list
      S_RELEASE: begin
        link_req_o.wr_en   = 1'b1;
        link_req_o.wr_addr = slot_idx(slot_q);
        link_req_o.wr_data = free_q;
        free_d             = slot_q;
        state_d            = S_DONE;
      end

      S_DONE: begin
        if (res_free_i) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // State, list pointers and result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      head_q       <= NIL_SLOT;
      tail_q       <= NIL_SLOT;
      free_q       <= '0;
      fresh_q      <= '0;
      count_q      <= '0;
      status_q     <= ST_MISS;
      res_handle_q <= '0;
      res_key_q    <= '0;
    end else begin
      state_q      <= state_d;
      head_q       <= head_d;
      tail_q       <= tail_d;
      free_q       <= free_d;
      fresh_q      <= fresh_d;
      count_q      <= count_d;
      status_q     <= status_d;
      res_handle_q <= res_handle_d;
      res_key_q    <= res_key_d;
    end
  end

  // Request and walk registers
  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    handle_q <= handle_d;
    key_q    <= key_d;
    slot_q   <= slot_d;
    prev_q   <= prev_d;
    link_q   <= link_d;
    steps_q  <= steps_d;
  end

endmodule

### rtl/linked_list_deque_with_key_removal_core.sv
// ---------------------------------------------------------------------------
// linked_list_deque_with_key_removal_core
// Bounded singly linked list of handle/key entries in a slot pool.
// ---------------------------------------------------------------------------
// One request is worked at a time; a new one is taken as soon as the previous
// result sits in the output register, even if it has not been collected. Push
// at tail takes an extra state to link the old tail on a non-empty list.
// Remove by key and pop from tail walk the links from the head through the
// link memory, one read per cycle, up to the matching entry or the tail.
// Reset is immediate: unused slots are issued from a fill pointer, so no
// clearing pass runs over the memories.
`include "linked_list_deque_with_key_removal_core_assert.svh"

module linked_list_deque_with_key_removal_core (
  input  logic   clk_i,
  input  logic   rst_ni,
  lldq_req_if.sink   req_i,
  lldq_rsp_if.source rsp_o
);
  import lldq_pkg::*;

  link_req_t          link_req;
  ent_req_t           ent_req;
  logic [SLOT_W-1:0]  link_rdata;
  logic [ENTRY_W-1:0] ent_rdata;
  logic               res_valid;
  result_t            res;
  logic               res_free;
  logic               out_valid_q;
  result_t            out_q;

  lldq_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_i.valid),
    .req_ready_o  (req_i.ready),
    .kind_i       (req_i.kind),
    .handle_i     (req_i.item_handle),
    .key_i        (req_i.item_key),
    .link_req_o   (link_req),
    .link_rdata_i (link_rdata),
    .ent_req_o    (ent_req),
    .ent_rdata_i  (ent_rdata),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .res_free_i   (res_free)
  );

  // Link per slot: list and free chain
  lldq_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_link_ram (
    .clk_i     (clk_i),
    .rd_en_i   (link_req.rd_en),
    .rd_addr_i (link_req.rd_addr),
    .rd_data_o (link_rdata),
    .wr_en_i   (link_req.wr_en),
    .wr_addr_i (link_req.wr_addr),
    .wr_data_i (link_req.wr_data)
  );

  // Handle and key per slot
  lldq_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_ent_ram (
    .clk_i     (clk_i),
    .rd_en_i   (ent_req.rd_en),
    .rd_addr_i (ent_req.rd_addr),
    .rd_data_o (ent_rdata),
    .wr_en_i   (ent_req.wr_en),
    .wr_addr_i (ent_req.wr_addr),
    .wr_data_i (ent_req.wr_data)
  );

  // Output register
  assign res_free = !out_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_free) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_free) begin
      out_q <= res;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_q.status;
  assign rsp_o.out_handle  = out_q.handle;
  assign rsp_o.out_key     = out_q.key;
  assign rsp_o.entry_count = COUNT_W'(out_q.count);

  // Checks
  `LLDQ_ASSERT(a_full_means_capacity, rsp_o.valid && rsp_o.status == ST_FULL, rsp_o.entry_count == COUNT_W'(CAPACITY))
  `LLDQ_ASSERT(a_count_bounded, out_valid_q, out_q.count <= CNT_W'(CAPACITY))
  `LLDQ_ASSERT(a_link_no_rw_overlap, link_req.wr_en, !link_req.rd_en)
  `LLDQ_ASSERT_NEXT(a_busy_after_accept, req_i.valid && req_i.ready, !req_i.ready)

endmodule
